// ===== rtl/core/lpht_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the linear probing hash table.
// Used by lpht_hash, lpht_store and linear_probe_hash_table_top.
package lpht_pkg;

  // Default table size and the fixed key length in bytes.
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int KEY_BYTES       = 8;

  // Seed of the byte hash.
  localparam logic [63:0] HASH_SEED = 64'h1337_1337_dead_beef;

  // Request codes. The last one has no operation behind it.
  localparam logic [1:0] FUNC_PUT    = 2'd0;
  localparam logic [1:0] FUNC_GET    = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // Slot marks.
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // One slot of the table as it sits in memory.
  typedef struct packed {
    logic [1:0]  mark;
    logic [63:0] key;
    logic [63:0] value;
  } entry_t;

  // Hash unit phases.
  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MIX,
    HS_MOD
  } hash_state_t;

  // Request sequencer states.
  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_HASH,
    CS_READ,
    CS_CHECK
  } ctl_state_t;

  // Keep bytes up to the first zero byte and at most KEY_BYTES bytes.
  function automatic logic [63:0] normalize_key(input logic [63:0] raw);
    logic [63:0] kept;
    logic        ended;
    kept  = '0;
    ended = 1'b0;
    for (int n = 0; n < 8; n++) begin
      if (raw[8*n +: 8] == 8'd0 || n >= KEY_BYTES) begin
        ended = 1'b1;
      end
      if (!ended) begin
        kept[8*n +: 8] = raw[8*n +: 8];
      end
    end
    return kept;
  endfunction

  // One byte step of the hash: xor the byte, shift left a byte, add the byte.
  function automatic logic [63:0] hash_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] t;
    t = (h ^ {56'd0, b}) << 8;
    return t + {56'd0, b};
  endfunction

endpackage

// ===== rtl/core/lpht_hash.sv =====
`timescale 1ns / 1ps
// Start slot unit: byte hash of the key, one byte a cycle, then the hash
// reduced modulo the table depth, eight bits a cycle. Depends on lpht_pkg.
module lpht_hash import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   key,
  output logic          done,
  output logic [AW-1:0] slot
);

  localparam logic [AW:0] DEPTH_W = (AW + 1)'(TABLE_DEPTH);

  hash_state_t   hs_r, hs_nxt;
  logic [63:0]   h_r, h_nxt;
  logic [63:0]   key_r, key_nxt;
  logic [AW-1:0] rem_r, rem_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] rem_step;

  // Remainder update over the next eight hash bits, most significant first.
  always_comb begin
    logic [AW:0]   t;
    logic [AW-1:0] r;
    r = rem_r;
    for (int i = 0; i < 8; i++) begin
      t = {r, h_r[63 - i]};
      if (t >= DEPTH_W) begin
        t = t - DEPTH_W;
      end
      r = t[AW-1:0];
    end
    rem_step = r;
  end

  assign done = (hs_r == HS_MOD) && (cnt_r == 3'd7);
  assign slot = rem_step;

  // Phase sequencing and datapath updates.
  always_comb begin
    hs_nxt  = hs_r;
    h_nxt   = h_r;
    key_nxt = key_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    unique case (hs_r)
      HS_IDLE: begin
        if (start) begin
          hs_nxt  = HS_MIX;
          h_nxt   = HASH_SEED;
          key_nxt = key;
        end
      end
      HS_MIX: begin
        // The key is zero past its end, so a zero byte ends the mixing.
        if (key_r[7:0] == 8'd0) begin
          hs_nxt  = HS_MOD;
          cnt_nxt = 3'd0;
          rem_nxt = '0;
        end else begin
          h_nxt   = hash_mix(h_r, key_r[7:0]);
          key_nxt = key_r >> 8;
        end
      end
      HS_MOD: begin
        rem_nxt = rem_step;
        h_nxt   = h_r << 8;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          hs_nxt = HS_IDLE;
        end
      end
      default: hs_nxt = HS_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r  <= HS_IDLE;
      cnt_r <= 3'd0;
    end else begin
      hs_r  <= hs_nxt;
      cnt_r <= cnt_nxt;
    end
    h_r   <= h_nxt;
    key_r <= key_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ===== rtl/core/lpht_store.sv =====
`timescale 1ns / 1ps
// Slot memory: one write port and one read port with registered read data.
// Depends on lpht_pkg for the slot layout.
module lpht_store import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/linear_probe_hash_table_top.sv =====
`timescale 1ns / 1ps
// Linear probing hash table: put, get and delete of keys up to 8 bytes.
// After accept, the key is hashed a byte a cycle until its end is seen, the hash is
// reduced modulo the table depth, each probed slot is read and then checked, and the
// result is registered. Code three skips hashing and probing and answers from idle.
// One request at a time; the next is accepted in the cycle its result is shown, and
// the receiver cannot stall. After reset the block is busy while the slots are cleared.
module linear_probe_hash_table_top import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key_bytes,
  input  logic [63:0] in_new_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_value,
  output logic [8:0]  out_entries_held
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  ctl_state_t    state_r, state_nxt;
  logic [1:0]    func_r, func_nxt;
  logic [63:0]   key_r, key_nxt;
  logic [63:0]   value_r, value_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] visited_r, visited_nxt;
  logic          free_found_r, free_found_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [63:0]   out_read_value_r, out_read_value_nxt;
  logic [8:0]    out_entries_r, out_entries_nxt;

  logic          accept;
  logic [63:0]   key_norm;
  logic          hash_start;
  logic          hash_done;
  logic [AW-1:0] hash_slot;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  entry_t        rd_data;

  logic          is_live;
  logic          is_match;
  logic          free_any;
  logic [AW-1:0] free_sel;

  assign busy       = (state_r != CS_IDLE);
  assign accept     = start && !busy;
  assign key_norm   = normalize_key(in_key_bytes);
  assign hash_start = accept && (in_func != FUNC_UNUSED);

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_read_value   = out_read_value_r;
  assign out_entries_held = out_entries_r;

  lpht_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key_norm),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  lpht_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Classification of the slot just read.
  assign is_live  = (rd_data.mark == MARK_LIVE);
  assign is_match = is_live && (rd_data.key == key_r);
  assign free_any = free_found_r || !is_live;
  assign free_sel = free_found_r ? free_idx_r : idx_r;

  // Request sequencer: clear pass, hashing, probe loop and write back.
  always_comb begin
    state_nxt          = state_r;
    func_nxt           = func_r;
    key_nxt            = key_r;
    value_nxt          = value_r;
    idx_nxt            = idx_r;
    visited_nxt        = visited_r;
    free_found_nxt     = free_found_r;
    free_idx_nxt       = free_idx_r;
    count_nxt          = count_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = out_status_r;
    out_read_value_nxt = out_read_value_r;
    out_entries_nxt    = out_entries_r;
    wr_en              = 1'b0;
    wr_addr            = idx_r;
    wr_data            = '{mark: MARK_LIVE, key: key_r, value: value_r};
    rd_en              = 1'b0;

    unique case (state_r)
      CS_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '{mark: MARK_EMPTY, key: '0, value: '0};
        idx_nxt = idx_r + AW'(1);
        if (idx_r == LAST_SLOT) begin
          idx_nxt   = '0;
          state_nxt = CS_IDLE;
        end
      end
      CS_IDLE: begin
        if (accept) begin
          func_nxt  = in_func;
          key_nxt   = key_norm;
          value_nxt = in_new_value;
          if (in_func == FUNC_UNUSED) begin
            // Unused code: answer at once, nothing changes.
            out_valid_nxt      = 1'b1;
            out_status_nxt     = STATUS_OK;
            out_read_value_nxt = '0;
            out_entries_nxt    = 9'(count_r);
          end else begin
            state_nxt = CS_HASH;
          end
        end
      end
      CS_HASH: begin
        if (hash_done) begin
          idx_nxt        = hash_slot;
          visited_nxt    = '0;
          free_found_nxt = 1'b0;
          state_nxt      = CS_READ;
        end
      end
      CS_READ: begin
        rd_en     = 1'b1;
        state_nxt = CS_CHECK;
      end
      CS_CHECK: begin
        if (!is_live && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        if (is_match) begin
          // Key found on its chain.
          state_nxt          = CS_IDLE;
          out_valid_nxt      = 1'b1;
          out_status_nxt     = STATUS_OK;
          out_read_value_nxt = '0;
          case (func_r)
            FUNC_PUT: begin
              wr_en = 1'b1;
            end
            FUNC_GET: begin
              out_read_value_nxt = rd_data.value;
            end
            FUNC_DELETE: begin
              wr_en   = 1'b1;
              wr_data = '{mark: MARK_TOMB, key: rd_data.key, value: rd_data.value};
              if (count_r != '0) begin
                count_nxt = count_r - CW'(1);
              end
            end
            default: out_read_value_nxt = '0;
          endcase
          out_entries_nxt = 9'(count_nxt);
        end else if (rd_data.mark == MARK_EMPTY || visited_r == LAST_SLOT) begin
          // Chain ends without the key.
          state_nxt          = CS_IDLE;
          out_valid_nxt      = 1'b1;
          out_read_value_nxt = '0;
          out_status_nxt     = STATUS_NOT_FOUND;
          if (func_r == FUNC_PUT) begin
            if (free_any) begin
              wr_en          = 1'b1;
              wr_addr        = free_sel;
              count_nxt      = count_r + CW'(1);
              out_status_nxt = STATUS_OK;
            end else begin
              out_status_nxt = STATUS_FULL;
            end
          end
          out_entries_nxt = 9'(count_nxt);
        end else begin
          // Step to the next slot, wrapping at the end of the table.
          visited_nxt = visited_r + AW'(1);
          idx_nxt     = (idx_r == LAST_SLOT) ? '0 : idx_r + AW'(1);
          state_nxt   = CS_READ;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= CS_CLEAR;
      idx_r        <= '0;
      visited_r    <= '0;
      free_found_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      visited_r    <= visited_nxt;
      free_found_r <= free_found_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    func_r           <= func_nxt;
    key_r            <= key_nxt;
    value_r          <= value_nxt;
    free_idx_r       <= free_idx_nxt;
    out_status_r     <= out_status_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_entries_r    <= out_entries_nxt;
  end

endmodule

// ===== tb/linear_probe_hash_table_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of linear_probe_hash_table_top: put, get and delete words
// are checked against a behavioral table model. Depends on lpht_pkg.
module linear_probe_hash_table_top_test;
  import lpht_pkg::*;

  localparam int DEPTH       = DEF_TABLE_DEPTH;
  localparam int POOL_SIZE   = 40;
  localparam int RANDOM_OPS  = 1250;
  localparam int FILL_PUTS   = 270;
  localparam int TAIL_CYCLES = 30;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key_bytes;
    logic [63:0] new_value;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [8:0]  entries_held;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_func = '0;
  logic [63:0] in_key_bytes = '0;
  logic [63:0] in_new_value = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [63:0] out_read_value;
  logic [8:0]  out_entries_held;

  // Table model state.
  logic [63:0] slot_key [DEPTH];
  logic [63:0] slot_value [DEPTH];
  logic [1:0]  slot_mark [DEPTH];
  int          live_count = 0;

  request_t pending_requests [$];
  reply_t   expected_replies [$];
  int       request_total = 0;
  int       accepted_count = 0;
  int       sent_count = 0;
  int       error_count = 0;
  int       cycle_count = 0;
  logic     accepted = 1'b0;

  linear_probe_hash_table_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_key_bytes     (in_key_bytes),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_read_value   (out_read_value),
    .out_entries_held (out_entries_held)
  );

  always #5 clk = ~clk;

  // Cut the key at its first zero byte.
  function automatic logic [63:0] trim_key(input logic [63:0] raw);
    logic [63:0] kept;
    int          n;
    kept = '0;
    n = 0;
    while (n < KEY_BYTES && raw[8*n +: 8] != 8'd0) begin
      kept[8*n +: 8] = raw[8*n +: 8];
      n++;
    end
    return kept;
  endfunction

  // Home slot of a trimmed key.
  function automatic int home_slot(input logic [63:0] key);
    logic [63:0] h;
    logic [7:0]  b;
    h = HASH_SEED;
    for (int n = 0; n < 8; n++) begin
      b = key[8*n +: 8];
      if (b == 8'd0) break;
      h = ((h ^ {56'd0, b}) << 8) + {56'd0, b};
    end
    return int'(h % 64'(DEPTH));
  endfunction

  // Walk the chain of a key. Returns the live slot holding it or -1, and the
  // first reusable slot seen on the way (or -1).
  function automatic int find_key(input logic [63:0] key, output int open_slot);
    int idx;
    int found;
    open_slot = -1;
    found = -1;
    idx = home_slot(key);
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_mark[idx] == MARK_LIVE) begin
        if (slot_key[idx] == key) begin
          found = idx;
          break;
        end
      end else begin
        if (open_slot < 0) open_slot = idx;
        if (slot_mark[idx] == MARK_EMPTY) break;
      end
      idx = (idx + 1) % DEPTH;
    end
    return found;
  endfunction

  // Apply one request to the table model and return the reply it should give.
  function automatic reply_t apply_request(input request_t rq);
    reply_t      r;
    logic [63:0] key;
    int          hit;
    int          open_slot;
    r.status = STATUS_OK;
    r.read_value = '0;
    key = trim_key(rq.key_bytes);
    case (rq.func)
      FUNC_PUT: begin
        hit = find_key(key, open_slot);
        if (hit >= 0) begin
          slot_value[hit] = rq.new_value;
        end else if (open_slot >= 0) begin
          slot_key[open_slot] = key;
          slot_value[open_slot] = rq.new_value;
          slot_mark[open_slot] = MARK_LIVE;
          live_count++;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      FUNC_GET: begin
        hit = find_key(key, open_slot);
        if (hit >= 0) r.read_value = slot_value[hit];
        else r.status = STATUS_NOT_FOUND;
      end
      FUNC_DELETE: begin
        hit = find_key(key, open_slot);
        if (hit >= 0) begin
          slot_mark[hit] = MARK_TOMB;
          if (live_count > 0) live_count--;
        end else begin
          r.status = STATUS_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.entries_held = 9'(live_count);
    return r;
  endfunction

  task automatic report(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic queue_request(input logic [1:0] func, input logic [63:0] key,
                               input logic [63:0] value);
    pending_requests.push_back('{func: func, key_bytes: key, new_value: value});
  endtask

  // Fill the bytes past the terminator with junk, which must not matter.
  function automatic logic [63:0] add_junk(input logic [63:0] key, input int len);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if (len >= 8) return key;
    return key | (junk & ~((64'd1 << (8 * (len + 1))) - 64'd1));
  endfunction

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Driver: present the next word once the previous one was taken, with
  // random idle cycles except in a quiet stretch in the middle of the run.
  always @(negedge clk) begin : drive
    request_t rq;
    logic     may_idle;
    if (rst_n && (!start || accepted)) begin
      may_idle = (sent_count < 500) || (sent_count >= 800);
      if (pending_requests.size() > 0 && !(may_idle && $urandom_range(0, 99) < 19)) begin
        rq = pending_requests.pop_front();
        start <= 1'b1;
        in_func <= rq.func;
        in_key_bytes <= rq.key_bytes;
        in_new_value <= rq.new_value;
        sent_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check the result word against the oldest expectation, then
  // record the request word taken at this edge.
  always @(posedge clk) begin : watch
    reply_t   want;
    request_t rq;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          report("result word with no request outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status)
            report($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_read_value !== want.read_value)
            report($sformatf("read_value %h, expected %h", out_read_value, want.read_value));
          if (out_entries_held !== want.entries_held)
            report($sformatf("entries_held %0d, expected %0d",
                             out_entries_held, want.entries_held));
        end
      end
      accepted = start && !busy;
      if (accepted) begin
        rq = '{func: in_func, key_bytes: in_key_bytes, new_value: in_new_value};
        expected_replies.push_back(apply_request(rq));
        accepted_count++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : main
    logic [63:0] key_pool [POOL_SIZE];
    int          pool_len [POOL_SIZE];
    logic [63:0] key;
    logic [1:0]  func;
    int          pick;
    int          r;

    for (int i = 0; i < DEPTH; i++) begin
      slot_mark[i] = MARK_EMPTY;
      slot_key[i] = '0;
      slot_value[i] = '0;
    end

    // Directed: empty key, full-length key, junk after the terminator, the
    // unused code, absent keys, an update past a tombstone, tombstone reuse
    // and a chain that wraps from the last slot to the first.
    queue_request(FUNC_GET, 64'd0, 64'd0);
    queue_request(FUNC_DELETE, 64'd0, 64'd0);
    queue_request(FUNC_PUT, 64'd0, '1);
    queue_request(FUNC_GET, 64'h0000_0000_FFFF_FF00, 64'd0);
    queue_request(FUNC_PUT, '1, 64'd0);
    queue_request(FUNC_GET, '1, '1);
    queue_request(FUNC_PUT, '1, 64'h0123_4567_89AB_CDEF);
    queue_request(FUNC_PUT, 64'hDEAD_BEEF_0000_0041, 64'd5);
    queue_request(FUNC_GET, 64'h0000_0000_0000_0041, 64'd0);
    queue_request(FUNC_UNUSED, '1, '1);
    queue_request(FUNC_DELETE, 64'h1234_5678_9A00_0041, 64'd0);
    queue_request(FUNC_GET, 64'h41, 64'd0);
    queue_request(FUNC_DELETE, 64'h41, 64'd0);
    // Keys whose last byte is 0x10 share a home slot.
    queue_request(FUNC_PUT, 64'h10, 64'd1);
    queue_request(FUNC_PUT, 64'h1020, 64'd2);
    queue_request(FUNC_PUT, 64'h1030, 64'd3);
    queue_request(FUNC_DELETE, 64'h1020, 64'd0);
    queue_request(FUNC_PUT, 64'h1030, 64'hAAAA_5555_AAAA_5555);
    queue_request(FUNC_GET, 64'h1030, 64'd0);
    queue_request(FUNC_PUT, 64'h1040, 64'd4);
    queue_request(FUNC_GET, 64'h1040, 64'd0);
    queue_request(FUNC_GET, 64'h1020, 64'd0);
    queue_request(FUNC_PUT, 64'hFF, 64'h8000_0000_0000_0001);
    queue_request(FUNC_GET, 64'hFF, 64'd0);

    // Key pool: half the keys end in one of three bytes, to build chains.
    key_pool[0] = 64'd0;
    pool_len[0] = 0;
    for (int i = 1; i < POOL_SIZE; i++) begin
      pool_len[i] = $urandom_range(1, 8);
      key_pool[i] = '0;
      for (int n = 0; n < pool_len[i]; n++) key_pool[i][8*n +: 8] = 8'($urandom_range(1, 255));
      if (i % 2 == 1) key_pool[i][8*(pool_len[i]-1) +: 8] = 8'(8'h20 + $urandom_range(0, 2));
    end

    // Random traffic: mostly pool keys, some fully random raw keys.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 44) func = FUNC_PUT;
      else if (r < 74) func = FUNC_GET;
      else if (r < 95) func = FUNC_DELETE;
      else func = FUNC_UNUSED;
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        key = ($urandom_range(0, 1) == 1) ? add_junk(key_pool[pick], pool_len[pick])
                                           : key_pool[pick];
      end else begin
        key = {$urandom, $urandom};
      end
      queue_request(func, key, {$urandom, $urandom});
    end

    // Fill the table with distinct full-length keys until puts report full.
    for (int i = 0; i < FILL_PUTS; i++) begin
      key = {8'($urandom_range(1, 255)), 40'hC3C3_C3C3_C3, 8'(1 + i / 255), 8'(1 + i % 255)};
      queue_request(FUNC_PUT, key, {$urandom, $urandom});
    end
    // At full: a put, an absent lookup and delete, then pool-key deletes, each with a new put and a get.
    queue_request(FUNC_PUT, {8'h11, 40'hC3C3_C3C3_C3, 8'd1, 8'd4}, 64'hFEED);
    queue_request(FUNC_GET, 64'h7E7E_7E7E_7E7E_7E7E, 64'd0);
    queue_request(FUNC_DELETE, 64'h7E7E_7E7E_7E7E_7E7E, 64'd0);
    for (int i = 0; i < 6; i++) begin
      pick = $urandom_range(0, POOL_SIZE - 1);
      queue_request(FUNC_DELETE, key_pool[pick], 64'd0);
      queue_request(FUNC_PUT, {8'h5A, 40'h3C3C_3C3C_3C, 8'($urandom_range(1, 255)), 8'(i + 1)},
                    {$urandom, $urandom});
      queue_request(FUNC_GET, key_pool[pick], 64'd0);
    end
    request_total = pending_requests.size();

    // Synchronous reset, released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_count < request_total || expected_replies.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lpht_pkg.sv
rtl/core/lpht_hash.sv
rtl/core/lpht_store.sv
rtl/core/linear_probe_hash_table_top.sv
tb/linear_probe_hash_table_top_test.sv
